@@ hw/rtl/psp_pkg.sv @@
// shared widths, constants and stage payload types of the point segment projection core
package psp_pkg;

   localparam int COORD_W = 32;
   localparam int DIFF_W = COORD_W + 1;
   localparam int LEN_W = 2 * DIFF_W;
   localparam int REM_W = LEN_W + 1;
   localparam int FRAC_BITS_DEFAULT = 16;

   // per-item flags that ride along the pipeline
   typedef struct packed {
      logic zero_len;
      logic point_match;
      logic in_range;
   } stat_type;

   // per-item operands carried to the output stage
   typedef struct packed {
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
      logic signed [COORD_W-1:0] st;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      stat_type stat;
   } item_type;

   // divider working values
   typedef struct packed {
      logic [LEN_W-1:0] len2;
      logic [REM_W-1:0] rem;
   } div_type;

endpackage

@@ hw/rtl/psp_front.sv @@
// differences, dot products, squared length, range check and integer quotient bit
module psp_front #(
   parameter int FRAC_BITS = psp_pkg::FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic signed [psp_pkg::COORD_W-1:0] point_x,
   input  logic signed [psp_pkg::COORD_W-1:0] point_y,
   input  logic signed [psp_pkg::COORD_W-1:0] start_x,
   input  logic signed [psp_pkg::COORD_W-1:0] start_y,
   input  logic signed [psp_pkg::COORD_W-1:0] start_stamp,
   input  logic signed [psp_pkg::COORD_W-1:0] end_x,
   input  logic signed [psp_pkg::COORD_W-1:0] end_y,
   output logic out_valid,
   input  logic out_ready,
   output psp_pkg::item_type out_item,
   output psp_pkg::div_type out_div,
   output logic [FRAC_BITS:0] out_q
);
   import psp_pkg::*;

   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic rdy0, rdy1, rdy2, rdy3;

   item_type item0_in, item0_ff, item1_ff, item2_ff, item3_in, item3_ff;
   logic signed [DIFF_W-1:0] ax_in, ay_in, ax_ff, ay_ff;
   logic signed [LEN_W-1:0] mxx_in, myy_in, mxy_in, myx_in;
   logic signed [LEN_W-1:0] mxx_ff, myy_ff, mxy_ff, myx_ff;
   logic [LEN_W-1:0] len2_in, len2_ff;
   logic signed [REM_W-1:0] num_in, num_ff;
   div_type div3_in, div3_ff;
   logic q0;
   logic [FRAC_BITS:0] q3_ff;

   // stage readiness, bubbles collapse
   assign rdy3 = !v3_ff || out_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign rdy0 = !v0_ff || rdy1;
   assign in_ready = rdy0;

   // stage 0: coordinate differences and equality tests
   always_comb begin
      item0_in.px = point_x;
      item0_in.py = point_y;
      item0_in.sx = start_x;
      item0_in.sy = start_y;
      item0_in.st = start_stamp;
      item0_in.dx = $signed({end_x[COORD_W-1], end_x}) - $signed({start_x[COORD_W-1], start_x});
      item0_in.dy = $signed({end_y[COORD_W-1], end_y}) - $signed({start_y[COORD_W-1], start_y});
      item0_in.stat.zero_len = (end_x == start_x) && (end_y == start_y);
      item0_in.stat.point_match = (point_x == end_x) && (point_y == end_y);
      item0_in.stat.in_range = 1'b0;
      ax_in = $signed({point_x[COORD_W-1], point_x}) - $signed({start_x[COORD_W-1], start_x});
      ay_in = $signed({point_y[COORD_W-1], point_y}) - $signed({start_y[COORD_W-1], start_y});
   end

   // stage 1: four products
   assign mxx_in = item0_ff.dx * item0_ff.dx;
   assign myy_in = item0_ff.dy * item0_ff.dy;
   assign mxy_in = ax_ff * item0_ff.dx;
   assign myx_in = ay_ff * item0_ff.dy;

   // stage 2: squared length and dot product
   assign len2_in = $unsigned(mxx_ff) + $unsigned(myy_ff);
   assign num_in = $signed({mxy_ff[LEN_W-1], mxy_ff}) + $signed({myx_ff[LEN_W-1], myx_ff});

   // stage 3: range check and integer quotient bit
   always_comb begin
      item3_in = item2_ff;
      item3_in.stat.in_range = !num_ff[REM_W-1] && ({1'b0, len2_ff} >= $unsigned(num_ff))
                               && !item2_ff.stat.zero_len;
      q0 = ($unsigned(num_ff) >= {1'b0, len2_ff});
      div3_in.len2 = len2_ff;
      div3_in.rem = q0 ? ($unsigned(num_ff) - {1'b0, len2_ff}) : $unsigned(num_ff);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= in_valid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (rdy0) begin
         item0_ff <= item0_in;
         ax_ff <= ax_in;
         ay_ff <= ay_in;
      end
      if (rdy1) begin
         item1_ff <= item0_ff;
         mxx_ff <= mxx_in;
         myy_ff <= myy_in;
         mxy_ff <= mxy_in;
         myx_ff <= myx_in;
      end
      if (rdy2) begin
         item2_ff <= item1_ff;
         len2_ff <= len2_in;
         num_ff <= num_in;
      end
      if (rdy3) begin
         item3_ff <= item3_in;
         div3_ff <= div3_in;
         q3_ff <= {{FRAC_BITS{1'b0}}, q0};
      end
   end

   assign out_valid = v3_ff;
   assign out_item = item3_ff;
   assign out_div = div3_ff;
   assign out_q = q3_ff;

endmodule

@@ hw/rtl/psp_div_step.sv @@
// one restoring division step producing one fraction bit of t
module psp_div_step #(
   parameter int FRAC_BITS = psp_pkg::FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  psp_pkg::item_type in_item,
   input  psp_pkg::div_type in_div,
   input  logic [FRAC_BITS:0] in_q,
   output logic out_valid,
   input  logic out_ready,
   output psp_pkg::item_type out_item,
   output psp_pkg::div_type out_div,
   output logic [FRAC_BITS:0] out_q
);
   import psp_pkg::*;

   logic valid_ff;
   logic rdy;
   logic [REM_W-1:0] rem_sh;
   logic bit_in;
   div_type div_in, div_ff;
   item_type item_ff;
   logic [FRAC_BITS:0] q_ff;

   assign rdy = !valid_ff || out_ready;
   assign in_ready = rdy;

   // shift remainder, compare and subtract
   always_comb begin
      rem_sh = {in_div.rem[REM_W-2:0], 1'b0};
      bit_in = (rem_sh >= {1'b0, in_div.len2});
      div_in.len2 = in_div.len2;
      div_in.rem = bit_in ? (rem_sh - {1'b0, in_div.len2}) : rem_sh;
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (rdy) begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (rdy) begin
         item_ff <= in_item;
         div_ff <= div_in;
         q_ff <= {in_q[FRAC_BITS-1:0], bit_in};
      end
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;
   assign out_div = div_ff;
   assign out_q = q_ff;

endmodule

@@ hw/rtl/psp_back.sv @@
// scaling by t, result select and output register
module psp_back #(
   parameter int FRAC_BITS = psp_pkg::FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  psp_pkg::item_type in_item,
   input  logic [FRAC_BITS:0] in_q,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_on_segment,
   output logic signed [psp_pkg::COORD_W-1:0] rsp_proj_x,
   output logic signed [psp_pkg::COORD_W-1:0] rsp_proj_y,
   output logic signed [psp_pkg::COORD_W-1:0] rsp_proj_stamp
);
   import psp_pkg::*;

   localparam int PROD_W = FRAC_BITS + 2 + DIFF_W;

   logic vp_ff, vo_ff;
   logic rdy_p, rdy_o;
   item_type item_ff;
   logic signed [FRAC_BITS+1:0] q_s;
   logic signed [PROD_W-1:0] px_in, py_in, pt_in, px_ff, py_ff, pt_ff;
   logic signed [PROD_W-1:0] sh_x, sh_y, sh_t;
   logic on_in, on_ff;
   logic signed [COORD_W-1:0] x_in, y_in, t_in, x_ff, y_ff, t_ff;

   assign rdy_o = !vo_ff || rsp_ready;
   assign rdy_p = !vp_ff || rdy_o;
   assign in_ready = rdy_p;

   // products with t
   assign q_s = $signed({1'b0, in_q});
   assign px_in = q_s * in_item.dx;
   assign py_in = q_s * in_item.dy;
   assign pt_in = q_s * $signed({in_item.st[COORD_W-1], in_item.st});

   // floor shift, offset by start, select pass-through
   always_comb begin
      sh_x = px_ff >>> FRAC_BITS;
      sh_y = py_ff >>> FRAC_BITS;
      sh_t = pt_ff >>> FRAC_BITS;
      if (item_ff.stat.in_range) begin
         on_in = 1'b1;
         x_in = item_ff.sx + sh_x[COORD_W-1:0];
         y_in = item_ff.sy + sh_y[COORD_W-1:0];
         t_in = sh_t[COORD_W-1:0];
      end else begin
         on_in = item_ff.stat.zero_len && item_ff.stat.point_match;
         x_in = item_ff.px;
         y_in = item_ff.py;
         t_in = '0;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (rdy_p) vp_ff <= in_valid;
         if (rdy_o) vo_ff <= vp_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (rdy_p) begin
         item_ff <= in_item;
         px_ff <= px_in;
         py_ff <= py_in;
         pt_ff <= pt_in;
      end
      if (rdy_o) begin
         on_ff <= on_in;
         x_ff <= x_in;
         y_ff <= y_in;
         t_ff <= t_in;
      end
   end

   assign rsp_valid = vo_ff;
   assign rsp_on_segment = on_ff;
   assign rsp_proj_x = x_ff;
   assign rsp_proj_y = y_ff;
   assign rsp_proj_stamp = t_ff;

endmodule

@@ hw/rtl/point_segment_projection_core.sv @@
// top level of the point segment projection core
//
// channel   ports   direction   contents
// request   req_*   in          query point, segment start with stamp, segment end
// response  rsp_*   out         on_segment flag, projected point, scaled stamp
//
// one item enters per cycle while the pipeline does not stall; the restoring divider, one
// quotient bit per stage, sits after four front stages and before two back stages
// reset clears only the stage valid bits
// each stage holds while its successor is full and stalled; empty stages still fill, so the
// request side keeps taking transfers while a result waits in the output register
module point_segment_projection_core #(
   parameter int FRAC_BITS = psp_pkg::FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [psp_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [psp_pkg::COORD_W-1:0] req_point_y,
   input  logic signed [psp_pkg::COORD_W-1:0] req_start_x,
   input  logic signed [psp_pkg::COORD_W-1:0] req_start_y,
   input  logic signed [psp_pkg::COORD_W-1:0] req_start_stamp,
   input  logic signed [psp_pkg::COORD_W-1:0] req_end_x,
   input  logic signed [psp_pkg::COORD_W-1:0] req_end_y,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_on_segment,
   output logic signed [psp_pkg::COORD_W-1:0] rsp_proj_x,
   output logic signed [psp_pkg::COORD_W-1:0] rsp_proj_y,
   output logic signed [psp_pkg::COORD_W-1:0] rsp_proj_stamp
);
   import psp_pkg::*;

   logic [FRAC_BITS:0] valid_w;
   logic [FRAC_BITS:0] ready_w;
   item_type item_w [0:FRAC_BITS];
   div_type div_w [0:FRAC_BITS];
   logic [FRAC_BITS:0] q_w [0:FRAC_BITS];

   // products, sums, range check
   psp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_valid),
      .in_ready(req_ready),
      .point_x(req_point_x),
      .point_y(req_point_y),
      .start_x(req_start_x),
      .start_y(req_start_y),
      .start_stamp(req_start_stamp),
      .end_x(req_end_x),
      .end_y(req_end_y),
      .out_valid(valid_w[0]),
      .out_ready(ready_w[0]),
      .out_item(item_w[0]),
      .out_div(div_w[0]),
      .out_q(q_w[0])
   );

   // fraction bits of t, one per stage
   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
      psp_div_step #(.FRAC_BITS(FRAC_BITS)) u_step (
         .clock(clock),
         .reset(reset),
         .in_valid(valid_w[k]),
         .in_ready(ready_w[k]),
         .in_item(item_w[k]),
         .in_div(div_w[k]),
         .in_q(q_w[k]),
         .out_valid(valid_w[k+1]),
         .out_ready(ready_w[k+1]),
         .out_item(item_w[k+1]),
         .out_div(div_w[k+1]),
         .out_q(q_w[k+1])
      );
   end

   // scale, select, output register
   psp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock),
      .reset(reset),
      .in_valid(valid_w[FRAC_BITS]),
      .in_ready(ready_w[FRAC_BITS]),
      .in_item(item_w[FRAC_BITS]),
      .in_q(q_w[FRAC_BITS]),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_on_segment(rsp_on_segment),
      .rsp_proj_x(rsp_proj_x),
      .rsp_proj_y(rsp_proj_y),
      .rsp_proj_stamp(rsp_proj_stamp)
   );

endmodule

@@ verif/tb_point_segment_projection_core.sv @@
// self-checking testbench of the point segment projection core
module tb_point_segment_projection_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = psp_pkg::FRAC_BITS_DEFAULT;
   localparam int RANDOM_HALF = 300;
   localparam int END_WAIT = FRAC + 20;
   localparam int LONG_HOLD = 400;

   typedef logic signed [psp_pkg::COORD_W-1:0] coord_type;

   localparam coord_type COORD_MAX = 32'sh7fff_ffff;
   localparam coord_type COORD_MIN = 32'sh8000_0000;
   localparam coord_type ONE = 32'sh0001_0000;
   localparam coord_type PAT_A = 32'shaaaa_aaaa;
   localparam coord_type PAT_5 = 32'sh5555_5555;

   // one request transfer
   typedef struct {
      coord_type point_x;
      coord_type point_y;
      coord_type start_x;
      coord_type start_y;
      coord_type start_stamp;
      coord_type end_x;
      coord_type end_y;
   } req_item_type;

   // one response transfer
   typedef struct {
      logic on_segment;
      coord_type proj_x;
      coord_type proj_y;
      coord_type proj_stamp;
   } proj_result_type;

   // shapes of random requests
   typedef enum int {
      SHAPE_ON_SEG,
      SHAPE_DEGENERATE,
      SHAPE_OUTSIDE,
      SHAPE_NOISE
   } shape_type;

   // receiver stall patterns
   typedef enum int {
      READY_ALWAYS,
      READY_HALF,
      READY_SPARSE,
      READY_TOGGLE
   } ready_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   coord_type req_point_x = '0;
   coord_type req_point_y = '0;
   coord_type req_start_x = '0;
   coord_type req_start_y = '0;
   coord_type req_start_stamp = '0;
   coord_type req_end_x = '0;
   coord_type req_end_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_on_segment;
   coord_type rsp_proj_x;
   coord_type rsp_proj_y;
   coord_type rsp_proj_stamp;

   req_item_type pending_q[$];
   proj_result_type projection_q[$];
   int error_count = 0;
   logic long_hold_go = 1'b0;

   point_segment_projection_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_point_x(req_point_x),
      .req_point_y(req_point_y),
      .req_start_x(req_start_x),
      .req_start_y(req_start_y),
      .req_start_stamp(req_start_stamp),
      .req_end_x(req_end_x),
      .req_end_y(req_end_y),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_on_segment(rsp_on_segment),
      .rsp_proj_x(rsp_proj_x),
      .rsp_proj_y(rsp_proj_y),
      .rsp_proj_stamp(rsp_proj_stamp)
   );

   // projection of the point onto the segment at full width
   function automatic proj_result_type project_point(req_item_type it);
      logic signed [71:0] dx;
      logic signed [71:0] dy;
      logic signed [71:0] len2;
      logic signed [71:0] dot;
      logic signed [71:0] t_q;
      logic signed [71:0] rx;
      logic signed [71:0] ry;
      logic signed [71:0] rt;
      logic [95:0] scaled;
      logic [95:0] len2_u;
      proj_result_type r;
      dx = $signed(it.end_x) - $signed(it.start_x);
      dy = $signed(it.end_y) - $signed(it.start_y);
      len2 = dx * dx + dy * dy;
      dot = ($signed(it.point_x) - $signed(it.start_x)) * dx
          + ($signed(it.point_y) - $signed(it.start_y)) * dy;
      r.on_segment = 1'b0;
      r.proj_x = it.point_x;
      r.proj_y = it.point_y;
      r.proj_stamp = '0;
      if (len2 == 0) begin
         // degenerate segment only matches the exact end point
         r.on_segment = (it.point_x == it.end_x) && (it.point_y == it.end_y);
      end else if (dot >= 0 && dot <= len2) begin
         // t truncated to FRAC fractional bits, products floored
         scaled = 96'(dot) << FRAC;
         len2_u = 96'(len2);
         t_q = 72'(scaled / len2_u);
         rx = $signed(it.start_x) + ((t_q * dx) >>> FRAC);
         ry = $signed(it.start_y) + ((t_q * dy) >>> FRAC);
         rt = (t_q * $signed(it.start_stamp)) >>> FRAC;
         r.proj_x = rx[31:0];
         r.proj_y = ry[31:0];
         r.proj_stamp = rt[31:0];
         r.on_segment = 1'b1;
      end
      return r;
   endfunction

   // random coordinate of random magnitude, extremes now and then
   function automatic coord_type rand_coord();
      int unsigned w;
      w = $urandom_range(1, 32);
      if ($urandom_range(0, 15) == 0) begin
         return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      end
      return $signed($urandom) >>> (32 - w);
   endfunction

   // small offset off the segment line
   function automatic coord_type rand_offset();
      if ($urandom_range(0, 1) == 0) begin
         return '0;
      end
      return $signed($urandom) >>> $urandom_range(18, 31);
   endfunction

   // random request, mostly built to land on the segment
   function automatic req_item_type random_item();
      req_item_type it;
      shape_type shape;
      int pick;
      longint k;
      longint dxl;
      longint dyl;
      pick = $urandom_range(0, 9);
      if (pick < 6) shape = SHAPE_ON_SEG;
      else if (pick == 6) shape = SHAPE_DEGENERATE;
      else if (pick == 7) shape = SHAPE_OUTSIDE;
      else shape = SHAPE_NOISE;
      it.start_x = rand_coord();
      it.start_y = rand_coord();
      it.start_stamp = rand_coord();
      it.end_x = rand_coord();
      it.end_y = rand_coord();
      it.point_x = rand_coord();
      it.point_y = rand_coord();
      dxl = longint'(it.end_x) - longint'(it.start_x);
      dyl = longint'(it.end_y) - longint'(it.start_y);
      case (shape)
         SHAPE_ON_SEG: begin
            k = $urandom_range(0, 256);
            if ($urandom_range(0, 7) == 0) begin
               // exact ends of the segment
               k = $urandom_range(0, 1) ? 256 : 0;
               it.point_x = coord_type'(longint'(it.start_x) + ((dxl * k) >>> 8));
               it.point_y = coord_type'(longint'(it.start_y) + ((dyl * k) >>> 8));
            end else begin
               it.point_x = coord_type'(longint'(it.start_x) + ((dxl * k) >>> 8)
                                        + longint'(rand_offset()));
               it.point_y = coord_type'(longint'(it.start_y) + ((dyl * k) >>> 8)
                                        + longint'(rand_offset()));
            end
         end
         SHAPE_DEGENERATE: begin
            it.end_x = it.start_x;
            it.end_y = it.start_y;
            if ($urandom_range(0, 1) == 0) begin
               it.point_x = it.end_x;
               it.point_y = it.end_y;
            end else if ($urandom_range(0, 1) == 0) begin
               it.point_x = it.end_x ^ (32'sh1 << $urandom_range(0, 31));
               it.point_y = it.end_y;
            end
         end
         SHAPE_OUTSIDE: begin
            k = $urandom_range(0, 1) ? -longint'($urandom_range(1, 256))
                                     : longint'($urandom_range(257, 512));
            it.point_x = coord_type'(longint'(it.start_x) + ((dxl * k) >>> 8)
                                     + longint'(rand_offset()));
            it.point_y = coord_type'(longint'(it.start_y) + ((dyl * k) >>> 8)
                                     + longint'(rand_offset()));
         end
         default: begin
            it.point_x = $urandom;
            it.point_y = $urandom;
            it.start_x = $urandom;
            it.start_y = $urandom;
            it.start_stamp = $urandom;
            it.end_x = $urandom;
            it.end_y = $urandom;
         end
      endcase
      return it;
   endfunction

   task automatic queue_item(coord_type px, coord_type py, coord_type sx, coord_type sy,
                             coord_type st, coord_type ex, coord_type ey);
      req_item_type it;
      it.point_x = px;
      it.point_y = py;
      it.start_x = sx;
      it.start_y = sy;
      it.start_stamp = st;
      it.end_x = ex;
      it.end_y = ey;
      pending_q.push_back(it);
   endtask

   task automatic wait_drained();
      while (pending_q.size() != 0 || req_valid || projection_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // request driver, bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         // retire an accepted transfer
         if (req_valid && req_ready) begin
            projection_q.push_back(project_point(pending_q.pop_front()));
            next_valid = 1'b0;
         end
         // offer the next item unless in a gap
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_q.size() > 0) begin
               req_point_x <= pending_q[0].point_x;
               req_point_y <= pending_q[0].point_y;
               req_start_x <= pending_q[0].start_x;
               req_start_y <= pending_q[0].start_y;
               req_start_stamp <= pending_q[0].start_stamp;
               req_end_x <= pending_q[0].end_x;
               req_end_y <= pending_q[0].end_y;
               next_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
         req_valid <= next_valid;
      end
   end

   // response stall pattern plus one long hold-off
   ready_mode_type ready_mode = READY_ALWAYS;
   int mode_left = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (long_hold_go && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               ready_mode = ready_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 128);
            end else begin
               mode_left--;
            end
            case (ready_mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_HALF: rsp_ready <= $urandom_range(0, 1);
               READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   // response monitor, compare against the oldest projection
   always @(posedge clock) begin
      proj_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (projection_q.size() == 0) begin
            $display("%0t: unexpected response transfer on_segment %0b x %0d y %0d stamp %0d",
                     $time, rsp_on_segment, rsp_proj_x, rsp_proj_y, rsp_proj_stamp);
            error_count++;
         end else begin
            want = projection_q.pop_front();
            if (rsp_on_segment !== want.on_segment) begin
               $display("%0t: on_segment expected %0b actual %0b",
                        $time, want.on_segment, rsp_on_segment);
               error_count++;
            end
            if (rsp_proj_x !== want.proj_x) begin
               $display("%0t: proj_x expected %0d actual %0d", $time, want.proj_x, rsp_proj_x);
               error_count++;
            end
            if (rsp_proj_y !== want.proj_y) begin
               $display("%0t: proj_y expected %0d actual %0d", $time, want.proj_y, rsp_proj_y);
               error_count++;
            end
            if (rsp_proj_stamp !== want.proj_stamp) begin
               $display("%0t: proj_stamp expected %0d actual %0d",
                        $time, want.proj_stamp, rsp_proj_stamp);
               error_count++;
            end
         end
      end
   end

   // stimulus sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero-length segments, match and near misses
      queue_item(32'sh0005_0000, -32'sh0003_0000, 32'sh0005_0000, -32'sh0003_0000, ONE,
                 32'sh0005_0000, -32'sh0003_0000);
      queue_item(32'sh0005_0001, -32'sh0003_0000, 32'sh0005_0000, -32'sh0003_0000, ONE,
                 32'sh0005_0000, -32'sh0003_0000);
      queue_item(32'sh0005_0000, -32'sh0002_ffff, 32'sh0005_0000, -32'sh0003_0000, ONE,
                 32'sh0005_0000, -32'sh0003_0000);
      queue_item(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX);
      queue_item('0, '0, '0, '0, '0, '0, '0);
      queue_item(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      queue_item(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
      queue_item(COORD_MAX, COORD_MIN, '0, '0, ONE, '0, '0);
      // segment ends and the middle
      queue_item(ONE, 2 * ONE, ONE, 2 * ONE, 3 * ONE, 4 * ONE, 6 * ONE);
      queue_item(4 * ONE, 6 * ONE, ONE, 2 * ONE, -3 * ONE, 4 * ONE, 6 * ONE);
      queue_item(ONE, 5 * ONE, '0, '0, 10 * ONE, 2 * ONE, '0);
      // just outside either end
      queue_item(-32'sh1, '0, '0, '0, ONE, 2 * ONE, '0);
      queue_item(2 * ONE + 1, '0, '0, '0, ONE, 2 * ONE, '0);
      queue_item(COORD_MAX, COORD_MIN, '0, '0, ONE, ONE, '0);
      queue_item(COORD_MIN, COORD_MAX, '0, '0, ONE, ONE, '0);
      // perpendicular through the start, truncated t, negative products
      queue_item(-ONE, ONE, '0, '0, ONE, ONE, ONE);
      queue_item(32'sh1, '0, '0, '0, COORD_MAX, 32'sh3, '0);
      queue_item('0, '0, ONE, '0, -7 * ONE, -2 * ONE, -ONE);
      queue_item('0, '0, ONE, '0, COORD_MIN, -2 * ONE, -ONE);
      // full range diagonals and bit patterns
      queue_item('0, '0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
      queue_item(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX);
      queue_item(PAT_A, PAT_5, PAT_5, PAT_A, PAT_A, PAT_A, PAT_5);
      queue_item(PAT_5, PAT_A, PAT_A, PAT_5, PAT_5, PAT_5, PAT_A);
      wait_drained();

      // first random half, then a full pause of the sender
      repeat (RANDOM_HALF) pending_q.push_back(random_item());
      wait_drained();

      // second random half with one long receiver hold-off
      repeat (RANDOM_HALF) pending_q.push_back(random_item());
      repeat (50) @(posedge clock);
      long_hold_go <= 1'b1;
      wait_drained();

      repeat (END_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ point_segment_projection_core.f @@
hw/rtl/psp_pkg.sv
hw/rtl/psp_front.sv
hw/rtl/psp_div_step.sv
hw/rtl/psp_back.sv
hw/rtl/point_segment_projection_core.sv
verif/tb_point_segment_projection_core.sv
